FILE: sv/dsrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrr_pkg: shared constants and helpers for the direction rotation unit
// Holds the CORDIC arctangent table, the internal Q2.30 format constants and
// the saturation helper used by the frame and rotation stages.
// ----------------------------------------------------------------------------
package dsrr_pkg;

  // Internal direction format is signed Q2.30.
  localparam int QFRAC        = 30;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
  localparam logic signed [31:0] THREE_HALVES = 32'sd1610612736;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

  // Clamp a wide signed value to the Q2.30 range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > Q_MAX) r = 32'sh7FFFFFFF;
      else if (v < Q_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  // Q2.30 product with floor; result kept wide for later sums.
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b);
      return p >>> QFRAC;
    end
  endfunction

endpackage

FILE: sv/dsrr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrr_cordic: pipelined sine/cosine of a turn fraction
// One CORDIC iteration per register stage plus one input stage for quadrant
// folding; a word enters every cycle when the pipeline advances.
// ----------------------------------------------------------------------------
module dsrr_cordic #(
  parameter int ANGLE_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ANGLE_WIDTH-1:0]    angle,
  output logic signed [31:0]        cos_q,
  output logic signed [31:0]        sin_q
);

  localparam int N = dsrr_pkg::CORDIC_STEPS;

  logic signed [33:0] xs [0:N];
  logic signed [33:0] ys [0:N];
  logic signed [33:0] zs [0:N];
  logic               ng [0:N];

  logic [31:0]        a32;
  logic signed [33:0] z_in;

  // Widen the angle to a 32-bit turn fraction.
  if (ANGLE_WIDTH >= 32) begin : g_wide
    assign a32 = angle[ANGLE_WIDTH-1 -: 32];
  end else begin : g_narrow
    assign a32 = {angle, {(32-ANGLE_WIDTH){1'b0}}};
  end
  assign z_in = 34'(signed'(a32));

  // Fold the angle into [-1/4, 1/4] turn.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= dsrr_pkg::CORDIC_X0;
      ys[0] <= '0;
      if (z_in > 34'sd1073741824) begin
        zs[0] <= z_in - 34'sd2147483648;
        ng[0] <= 1'b1;
      end else if (z_in < -34'sd1073741824) begin
        zs[0] <= z_in + 34'sd2147483648;
        ng[0] <= 1'b1;
      end else begin
        zs[0] <= z_in;
        ng[0] <= 1'b0;
      end
    end
  end

  // One rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [33:0] at;
    assign at = 34'(dsrr_pkg::atan_turn(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + at;
        end
      end
    end
  end

  assign cos_q = ng[N] ? 32'(-xs[N]) : 32'(xs[N]);
  assign sin_q = ng[N] ? 32'(-ys[N]) : 32'(ys[N]);

endmodule

FILE: sv/dsrr_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrr_frame: pipelined sinTheta0 and the frame cosines cosPhi0, sinPhi0
// A restoring square root at one result bit a stage, then two restoring
// dividers at one quotient bit a stage.
// ----------------------------------------------------------------------------
module dsrr_frame (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  output logic signed [31:0] s0,
  output logic signed [31:0] cp0,
  output logic signed [31:0] sp0
);

  // 32 root stages, 1 setup, 62 quotient stages.
  localparam int RS = 32;
  localparam int QB = 62;

  // Square root pipeline: remainder, partial root, operand copies.
  logic [63:0] rn [0:RS];
  logic [63:0] rr [0:RS];
  logic signed [31:0] px [0:RS];
  logic signed [31:0] py [0:RS];

  logic [63:0] sq_sum;
  always_comb begin
    sq_sum = 64'(64'(x) * 64'(x)) + 64'(64'(y) * 64'(y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn[0] <= sq_sum;
      rr[0] <= '0;
      px[0] <= x;
      py[0] <= y;
    end
  end

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    always_ff @(posedge clk) begin
      if (en) begin
        px[k+1] <= px[k];
        py[k+1] <= py[k];
        if (rn[k] >= rr[k] + BIT) begin
          rn[k+1] <= rn[k] - (rr[k] + BIT);
          rr[k+1] <= (rr[k] >> 1) + BIT;
        end else begin
          rn[k+1] <= rn[k];
          rr[k+1] <= rr[k] >> 1;
        end
      end
    end
  end

  // Division setup: magnitudes shifted by 30, divisor the saturated root.
  logic [31:0] dv  [0:QB];
  logic [62:0] nrx [0:QB];
  logic [62:0] nry [0:QB];
  logic [61:0] qx  [0:QB];
  logic [61:0] qy  [0:QB];
  logic [61:0] dx  [0:QB];
  logic [61:0] dy  [0:QB];
  logic        sx  [0:QB];
  logic        sy  [0:QB];
  logic        zr  [0:QB];

  logic [31:0] root_s;
  logic [32:0] mx, my;
  always_comb begin
    root_s = (rr[RS] > 64'd2147483647) ? 32'h7FFFFFFF : rr[RS][31:0];
    mx = px[RS][31] ? 33'(-34'(px[RS])) : 33'(px[RS]);
    my = py[RS][31] ? 33'(-34'(py[RS])) : 33'(py[RS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]  <= root_s;
      nrx[0] <= '0;
      nry[0] <= '0;
      qx[0]  <= '0;
      qy[0]  <= '0;
      dx[0]  <= {29'd0, mx} << 30;
      dy[0]  <= {29'd0, my} << 30;
      sx[0]  <= px[RS][31];
      sy[0]  <= py[RS][31];
      zr[0]  <= (root_s == 32'd0);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [62:0] tx, ty;
    assign tx = {nrx[k][61:0], dx[k][61]};
    assign ty = {nry[k][61:0], dy[k][61]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        sx[k+1] <= sx[k];
        sy[k+1] <= sy[k];
        zr[k+1] <= zr[k];
        dx[k+1] <= dx[k] << 1;
        dy[k+1] <= dy[k] << 1;
        if (tx >= 63'(dv[k])) begin
          nrx[k+1] <= tx - 63'(dv[k]);
          qx[k+1]  <= {qx[k][60:0], 1'b1};
        end else begin
          nrx[k+1] <= tx;
          qx[k+1]  <= {qx[k][60:0], 1'b0};
        end
        if (ty >= 63'(dv[k])) begin
          nry[k+1] <= ty - 63'(dv[k]);
          qy[k+1]  <= {qy[k][60:0], 1'b1};
        end else begin
          nry[k+1] <= ty;
          qy[k+1]  <= {qy[k][60:0], 1'b0};
        end
      end
    end
  end

  // Apply signs and saturate; a vertical direction gives cos 1, sin 0.
  logic signed [63:0] vx, vy;
  always_comb begin
    vx = sx[QB] ? -64'(qx[QB]) : 64'(qx[QB]);
    vy = sy[QB] ? -64'(qy[QB]) : 64'(qy[QB]);
  end

  assign s0  = signed'(dv[QB]);
  assign cp0 = zr[QB] ? dsrr_pkg::Q_ONE : dsrr_pkg::sat32(vx);
  assign sp0 = zr[QB] ? 32'sd0 : dsrr_pkg::sat32(vy);

endmodule

FILE: sv/dsrr_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrr_rotate: rotation into the lab frame and renormalization
// Eight register stages; products are registered before they are summed.
// ----------------------------------------------------------------------------
module dsrr_rotate (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ct,
  input  logic signed [31:0] st,
  input  logic signed [31:0] cp,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] s0,
  input  logic signed [31:0] cp0,
  input  logic signed [31:0] sp0,
  input  logic signed [31:0] z,
  output logic signed [31:0] nx_out,
  output logic signed [31:0] ny_out,
  output logic signed [31:0] nz_out
);

  // Stage A: h0, h2 and s0*ct, ct*z.
  logic signed [31:0] a_h0, a_h2, a_cp0, a_sp0, a_s0, a_z;
  logic signed [63:0] a_s0ct, a_ctz;
  always_ff @(posedge clk) begin
    if (en) begin
      a_h0   <= dsrr_pkg::sat32(dsrr_pkg::qmul(st, cp));
      a_h2   <= dsrr_pkg::sat32(dsrr_pkg::qmul(st, sp));
      a_s0ct <= dsrr_pkg::qmul(s0, ct);
      a_ctz  <= dsrr_pkg::qmul(ct, z);
      a_cp0  <= cp0;
      a_sp0  <= sp0;
      a_s0   <= s0;
      a_z    <= z;
    end
  end

  // Stage B: z*h0 and h0*s0.
  logic signed [63:0] b_zh0, b_h0s0, b_s0ct, b_ctz;
  logic signed [31:0] b_h2, b_cp0, b_sp0;
  always_ff @(posedge clk) begin
    if (en) begin
      b_zh0  <= dsrr_pkg::qmul(a_z, a_h0);
      b_h0s0 <= dsrr_pkg::qmul(a_h0, a_s0);
      b_s0ct <= a_s0ct;
      b_ctz  <= a_ctz;
      b_h2   <= a_h2;
      b_cp0  <= a_cp0;
      b_sp0  <= a_sp0;
    end
  end

  // Stage C: h1 and nz.
  logic signed [31:0] c_h1, c_h2, c_cp0, c_sp0, c_nz;
  always_ff @(posedge clk) begin
    if (en) begin
      c_h1  <= dsrr_pkg::sat32(b_s0ct + b_zh0);
      c_nz  <= dsrr_pkg::sat32(b_ctz - b_h0s0);
      c_h2  <= b_h2;
      c_cp0 <= b_cp0;
      c_sp0 <= b_sp0;
    end
  end

  // Stage D: the four frame products.
  logic signed [63:0] d_p1, d_p2, d_p3, d_p4;
  logic signed [31:0] d_nz;
  always_ff @(posedge clk) begin
    if (en) begin
      d_p1 <= dsrr_pkg::qmul(c_h1, c_cp0);
      d_p2 <= dsrr_pkg::qmul(c_h2, c_sp0);
      d_p3 <= dsrr_pkg::qmul(c_h1, c_sp0);
      d_p4 <= dsrr_pkg::qmul(c_h2, c_cp0);
      d_nz <= c_nz;
    end
  end

  // Stage E: nx, ny.
  logic signed [31:0] e_nx, e_ny, e_nz;
  always_ff @(posedge clk) begin
    if (en) begin
      e_nx <= dsrr_pkg::sat32(d_p1 - d_p2);
      e_ny <= dsrr_pkg::sat32(d_p3 + d_p4);
      e_nz <= d_nz;
    end
  end

  // Stage F: squares.
  logic [63:0] f_qx, f_qy, f_qz;
  logic signed [31:0] f_nx, f_ny, f_nz;
  always_ff @(posedge clk) begin
    if (en) begin
      f_qx <= 64'(64'(e_nx) * 64'(e_nx));
      f_qy <= 64'(64'(e_ny) * 64'(e_ny));
      f_qz <= 64'(64'(e_nz) * 64'(e_nz));
      f_nx <= e_nx;
      f_ny <= e_ny;
      f_nz <= e_nz;
    end
  end

  // Stage G: delta = 1.5 - |n|^2 / 2.
  logic [63:0] n2;
  logic signed [31:0] g_delta, g_nx, g_ny, g_nz;
  always_comb begin
    n2 = f_qx + f_qy + f_qz;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_delta <= dsrr_pkg::sat32(64'(dsrr_pkg::THREE_HALVES) - signed'(64'(n2 >> 31)));
      g_nx <= f_nx;
      g_ny <= f_ny;
      g_nz <= f_nz;
    end
  end

  // Stage H: scale.
  always_ff @(posedge clk) begin
    if (en) begin
      nx_out <= dsrr_pkg::sat32(dsrr_pkg::qmul(g_nx, g_delta));
      ny_out <= dsrr_pkg::sat32(dsrr_pkg::qmul(g_ny, g_delta));
      nz_out <= dsrr_pkg::sat32(dsrr_pkg::qmul(g_nz, g_delta));
    end
  end

endmodule

FILE: sv/direction_scatter_rotate_renorm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_scatter_rotate_renorm_unit: rotate-to-z direction update
// Input words carry a direction, a polar and an azimuth angle and a track tag;
// each gives one output word with the rotated, renormalized direction.
// Both channels use valid/stall. The whole pipeline advances together
// whenever the output stage is empty or not stalled, so one word is accepted
// per cycle when the receiver keeps stall low.
// From input acceptance to output valid, a word passes the input register,
// the square root and two bit-serial-per-stage dividers (one bit per stage),
// in parallel with the 31-stage sine/cosine units, then 8 rotation stages.
// The divider chain sets the latency; throughput is one word per cycle while the receiver keeps stall low.
// When the receiver stalls a valid output word, the pipeline freezes; stall reaches the input
// only when a valid word sits in the output register.
// Reset clears the valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
module direction_scatter_rotate_renorm_unit #(
  parameter int DIR_WIDTH   = 32,
  parameter int ANGLE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DIR_WIDTH-1:0]   dir_x,
  input  logic [DIR_WIDTH-1:0]   dir_y,
  input  logic [DIR_WIDTH-1:0]   dir_z,
  input  logic [ANGLE_WIDTH-1:0] polar_angle,
  input  logic [ANGLE_WIDTH-1:0] azimuth_angle,
  input  logic [15:0]            track_tag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIR_WIDTH-1:0]   new_dir_x,
  output logic [DIR_WIDTH-1:0]   new_dir_y,
  output logic [DIR_WIDTH-1:0]   new_dir_z,
  output logic [15:0]            track_tag_out
);

  localparam int FRAME_LAT = 96;
  localparam int TRIG_LAT  = dsrr_pkg::CORDIC_STEPS + 1;
  localparam int ROT_LAT   = 8;
  localparam int LAT       = FRAME_LAT + ROT_LAT;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Bring the direction into Q2.30.
  function automatic logic signed [31:0] to_q(input logic [DIR_WIDTH-1:0] v);
    logic signed [DIR_WIDTH-1:0] s;
    begin
      s = signed'(v);
      if (DIR_WIDTH >= 32) return 32'(s >>> (DIR_WIDTH - 32));
      else return 32'(s) <<< (32 - DIR_WIDTH);
    end
  endfunction

  logic signed [31:0] qx, qy, qz;
  assign qx = to_q(dir_x);
  assign qy = to_q(dir_y);
  assign qz = to_q(dir_z);

  // Valid bits and tag travel alongside the datapath.
  logic        vld [0:LAT];
  logic [15:0] tag [0:LAT];
  assign vld[0] = in_valid;
  assign tag[0] = track_tag;
  for (genvar k = 0; k < LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) tag[k+1] <= tag[k];
    end
  end

  // Old z delayed to meet the frame results.
  logic signed [31:0] zd [0:FRAME_LAT];
  assign zd[0] = qz;
  for (genvar k = 0; k < FRAME_LAT; k++) begin : g_zd
    always_ff @(posedge clk) begin
      if (en) zd[k+1] <= zd[k];
    end
  end

  // Angles delayed so the sine/cosine results align with the frame results.
  localparam int ADLY = FRAME_LAT - TRIG_LAT;
  logic [ANGLE_WIDTH-1:0] pa [0:ADLY];
  logic [ANGLE_WIDTH-1:0] aa [0:ADLY];
  assign pa[0] = polar_angle;
  assign aa[0] = azimuth_angle;
  for (genvar k = 0; k < ADLY; k++) begin : g_ad
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k+1] <= pa[k];
        aa[k+1] <= aa[k];
      end
    end
  end

  logic signed [31:0] ct, st, cp, sp, s0, cp0, sp0;

  dsrr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_theta (
    .clk(clk), .en(en), .angle(pa[ADLY]), .cos_q(ct), .sin_q(st)
  );

  dsrr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_phi (
    .clk(clk), .en(en), .angle(aa[ADLY]), .cos_q(cp), .sin_q(sp)
  );

  dsrr_frame u_frame (
    .clk(clk), .en(en), .x(qx), .y(qy), .s0(s0), .cp0(cp0), .sp0(sp0)
  );

  logic signed [31:0] nx, ny, nz;

  dsrr_rotate u_rot (
    .clk(clk), .en(en), .ct(ct), .st(st), .cp(cp), .sp(sp), .s0(s0),
    .cp0(cp0), .sp0(sp0), .z(zd[FRAME_LAT]),
    .nx_out(nx), .ny_out(ny), .nz_out(nz)
  );

  // Convert back to the port width.
  function automatic logic [DIR_WIDTH-1:0] from_q(input logic signed [31:0] v);
    begin
      if (DIR_WIDTH >= 32) return DIR_WIDTH'(signed'(v)) << (DIR_WIDTH - 32);
      else return DIR_WIDTH'(v >>> (32 - DIR_WIDTH));
    end
  endfunction

  assign out_valid     = vld[LAT];
  assign track_tag_out = tag[LAT];
  assign new_dir_x     = from_q(nx);
  assign new_dir_y     = from_q(ny);
  assign new_dir_z     = from_q(nz);

endmodule

FILE: sv/dsrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrr_checker: port-level checks for the direction rotation unit
// Watches the handshakes on both channels and the stall coupling.
// ----------------------------------------------------------------------------
module dsrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] track_tag_out
);

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its tag.
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(track_tag_out))
    else $error("output tag changed while stalled");

  // Input is stalled only when a stalled word sits at the output.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  // A stalled input word stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input word withdrawn while stalled");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind direction_scatter_rotate_renorm_unit dsrr_checker u_dsrr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .track_tag_out(track_tag_out)
);
